// ===== hdl/sfs_pkg.sv =====
`default_nettype none

package sfs_pkg;

  // Field and register widths.
  localparam int SHEET_W       = 16;
  localparam int TIMER_W       = 16;
  localparam int TIMEOUT_W     = 16;
  localparam int BOX_W         = 2;
  localparam int OPCODE_W      = 1;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 16;

  // Input item opcodes.
  localparam logic [OPCODE_W-1:0] OP_TICK = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_JOB  = 1'b1;

  // Reported box state codes.
  localparam logic [BOX_W-1:0] BOX_IDLE   = 2'd0;
  localparam logic [BOX_W-1:0] BOX_FEED   = 2'd1;
  localparam logic [BOX_W-1:0] BOX_OUTPUT = 2'd2;
  localparam logic [BOX_W-1:0] BOX_ERROR  = 2'd3;

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_W-1:0] CFG_FEED_TIMEOUT   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_TIMEOUT = 1'd1;
  localparam logic [TIMEOUT_W-1:0]   FEED_TIMEOUT_RESET   = 16'd1000;
  localparam logic [TIMEOUT_W-1:0]   OUTPUT_TIMEOUT_RESET = 16'd1000;

  // Job queue status seen by the phase controller.
  typedef struct packed {
    logic               empty;
    logic               full;
    logic [SHEET_W-1:0] head_sheets;
  } queue_status_t;

endpackage

`default_nettype wire

// ===== hdl/sfs_item_if.sv =====
`default_nettype none

interface sfs_item_if;
  import sfs_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic                upper_sensor;
  logic                lower_sensor;
  logic [SHEET_W-1:0]  sheet_count;

  modport source (output valid, output opcode, output upper_sensor,
                  output lower_sensor, output sheet_count, input ready);
  modport sink   (input valid, input opcode, input upper_sensor,
                  input lower_sensor, input sheet_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/sfs_result_if.sv =====
`default_nettype none

interface sfs_result_if;
  import sfs_pkg::*;

  logic             valid;
  logic             ready;
  logic [BOX_W-1:0] box_state;
  logic             keep_printing;
  logic             job_retired;
  logic             queue_full;

  modport source (output valid, output box_state, output keep_printing,
                  output job_retired, output queue_full, input ready);
  modport sink   (input valid, input box_state, input keep_printing,
                  input job_retired, input queue_full, output ready);
endinterface

`default_nettype wire

// ===== hdl/sfs_cfg_if.sv =====
`default_nettype none

interface sfs_cfg_if;
  import sfs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/sfs_job_queue.sv =====
`default_nettype none

module sfs_job_queue #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire logic [sfs_pkg::SHEET_W-1:0] push_sheets,
  input  wire logic                        pop,
  output sfs_pkg::queue_status_t           status
);
  import sfs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W:0]   LAST_SLOT  = (PTR_W + 1)'(QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] wide;
    wide = {1'b0, p};
    return (wide >= LAST_SLOT) ? '0 : PTR_W'(wide + 1'b1);
  endfunction

  logic [SHEET_W-1:0] store [QUEUE_DEPTH];
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   head_next;
  logic [PTR_W-1:0]   tail;
  logic [CNT_W-1:0]   used;
  logic [SHEET_W-1:0] head_sheets;

  assign head_next = pop ? next_slot(head) : head;

  always_ff @(posedge clk) begin
    if (push) begin
      store[tail] <= push_sheets;
    end
  end

  // The head entry is read every cycle at the address the head will hold
  // next, so it is ready for a pop on the very next item. A write to that
  // same slot is forwarded.
  always_ff @(posedge clk) begin
    if (push && (tail == head_next)) begin
      head_sheets <= push_sheets;
    end else begin
      head_sheets <= store[head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      used <= '0;
    end else begin
      head <= head_next;
      if (push) begin
        tail <= next_slot(tail);
        used <= used + 1'b1;
      end else if (pop) begin
        used <= used - 1'b1;
      end
    end
  end

  assign status.empty       = (used == '0);
  assign status.full        = (used == FULL_COUNT);
  assign status.head_sheets = head_sheets;

endmodule

`default_nettype wire

// ===== hdl/sfs_phase_ctrl.sv =====
`default_nettype none

module sfs_phase_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          tick,
  input  wire logic                          upper,
  input  wire logic                          lower,
  input  wire logic [sfs_pkg::TIMEOUT_W-1:0] feed_timeout,
  input  wire logic [sfs_pkg::TIMEOUT_W-1:0] output_timeout,
  input  wire sfs_pkg::queue_status_t        queue_status,
  output logic                               pop,
  output logic                               retired,
  output logic [sfs_pkg::BOX_W-1:0]          box_state
);
  import sfs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_FEED       = 3'd1,
    PH_OUTPUT     = 3'd2,
    PH_IDLE_ERR   = 3'd3,
    PH_FEED_ERR   = 3'd4,
    PH_OUTPUT_ERR = 3'd5
  } phase_t;

  phase_t             phase;
  phase_t             phase_next;
  logic [TIMER_W-1:0] phase_timer;
  logic [TIMER_W-1:0] phase_timer_next;
  logic [TIMER_W-1:0] timer_bumped;
  logic               job_active;
  logic               job_active_next;
  logic [SHEET_W-1:0] sheets_left;
  logic [SHEET_W-1:0] sheets_left_next;
  logic               enter_idle;

  assign timer_bumped = (phase_timer == '1) ? phase_timer : phase_timer + 1'b1;

  // One tick runs the whole transition chain: a phase that ends falls
  // through to idle, which may start the next sheet in the same tick.
  always_comb begin
    phase_next       = phase;
    phase_timer_next = phase_timer;
    job_active_next  = job_active;
    sheets_left_next = sheets_left;
    pop              = 1'b0;
    retired          = 1'b0;
    enter_idle       = 1'b0;
    if (tick) begin
      case (phase)
        PH_FEED: begin
          if (upper) begin
            phase_next       = PH_OUTPUT;
            phase_timer_next = '0;
          end else if (phase_timer >= feed_timeout) begin
            // The feed error leaves at once when the lower sensor is on.
            enter_idle = 1'b1;
          end else begin
            phase_timer_next = timer_bumped;
          end
        end
        PH_OUTPUT: begin
          if (!upper) begin
            if (sheets_left <= SHEET_W'(1)) begin
              sheets_left_next = '0;
              job_active_next  = 1'b0;
              retired          = 1'b1;
            end else begin
              sheets_left_next = sheets_left - 1'b1;
            end
            enter_idle = 1'b1;
          end else if (phase_timer >= output_timeout) begin
            phase_next = PH_OUTPUT_ERR;
          end else begin
            phase_timer_next = timer_bumped;
          end
        end
        PH_IDLE_ERR, PH_FEED_ERR, PH_OUTPUT_ERR: begin
          enter_idle = lower && !upper;
        end
        default: begin
          enter_idle = 1'b1;
        end
      endcase

      if (enter_idle) begin
        if (!lower) begin
          phase_next = PH_FEED_ERR;
        end else begin
          if (!job_active_next && !queue_status.empty) begin
            sheets_left_next = queue_status.head_sheets;
            job_active_next  = 1'b1;
            pop              = 1'b1;
          end
          if (job_active_next) begin
            phase_next       = PH_FEED;
            phase_timer_next = '0;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_timer <= '0;
      job_active  <= 1'b0;
      sheets_left <= '0;
    end else begin
      phase       <= phase_next;
      phase_timer <= phase_timer_next;
      job_active  <= job_active_next;
      sheets_left <= sheets_left_next;
    end
  end

  always_comb begin
    case (phase_next)
      PH_FEED:                                 box_state = BOX_FEED;
      PH_OUTPUT:                               box_state = BOX_OUTPUT;
      PH_IDLE_ERR, PH_FEED_ERR, PH_OUTPUT_ERR: box_state = BOX_ERROR;
      default:                                 box_state = BOX_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/sheet_feeder_sequencer.sv =====
// Sheet feeder sequencer.
// The items channel carries either a one-millisecond tick with the upper and
// lower sensor levels (opcode tick) or a new job with its sheet count (opcode
// job), which is queued first in, first out. Every item produces exactly one
// result on the results channel: the box state after the item, keep_printing,
// a flag that the current job retired on this tick, and a flag that a job was
// dropped because the queue was full.
// The result of an accepted item is registered and presented in the next cycle.
// Throughput is one item per cycle while the receiver keeps up; the whole tick
// transition chain settles in one pass of logic between the phase registers,
// and the queue head is prefetched from the job store so a pop costs nothing.
// When the receiver stalls, the result waits in the output register and the
// block still takes an item in the cycle that result is taken.
// The cfg channel is always ready and writes the feed and output timeouts.
// Reset (synchronous, active high) returns to idle with no job, an empty
// queue, both timeouts at 1000 ticks and no result pending.
`default_nettype none

module sheet_feeder_sequencer #(
  parameter int QUEUE_DEPTH = 8
) (
  input wire logic     clk,
  input wire logic     rst,
  sfs_item_if.sink     items,
  sfs_result_if.source results,
  sfs_cfg_if.sink      cfg
);
  import sfs_pkg::*;

  logic                 accept;
  logic                 is_job;
  logic                 tick;
  logic                 push;
  logic                 pop;
  logic                 retired;
  logic [BOX_W-1:0]     box_state;
  queue_status_t        queue_status;
  logic [TIMEOUT_W-1:0] feed_timeout;
  logic [TIMEOUT_W-1:0] output_timeout;

  // A new item is taken whenever the output register is empty or its
  // result is leaving in this same cycle.
  assign items.ready = !results.valid || results.ready;
  assign accept      = items.valid && items.ready;
  assign is_job      = (items.opcode == OP_JOB);
  assign tick        = accept && (items.opcode == OP_TICK);
  assign push        = accept && is_job && !queue_status.full;

  sfs_job_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_job_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_sheets (items.sheet_count),
    .pop         (pop),
    .status      (queue_status)
  );

  sfs_phase_ctrl u_phase_ctrl (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .upper          (items.upper_sensor),
    .lower          (items.lower_sensor),
    .feed_timeout   (feed_timeout),
    .output_timeout (output_timeout),
    .queue_status   (queue_status),
    .pop            (pop),
    .retired        (retired),
    .box_state      (box_state)
  );

  // Timeout registers. The user must write them only while the block is idle; the block itself does not enforce it.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_timeout   <= FEED_TIMEOUT_RESET;
      output_timeout <= OUTPUT_TIMEOUT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FEED_TIMEOUT:   feed_timeout   <= TIMEOUT_W'(cfg.data);
        CFG_OUTPUT_TIMEOUT: output_timeout <= TIMEOUT_W'(cfg.data);
        default: begin
        end
      endcase
    end
  end

  // Output register. The valid flag is control state; the payload is
  // loaded only when an item is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (accept) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      results.box_state     <= box_state;
      results.keep_printing <= (box_state == BOX_FEED) || (box_state == BOX_OUTPUT);
      results.job_retired   <= retired;
      results.queue_full    <= is_job && queue_status.full;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sheet_feeder_sequencer_test.sv =====
`default_nettype none

module sheet_feeder_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sfs_pkg::*;

  // The block keeps up to this many queued jobs. The predictor mirrors the depth.
  localparam int QUEUE_DEPTH = 8;
  // This many cycles with nothing accepted on any channel end the run as hung.
  // The longest legal quiet stretch is the long receiver hold-off.
  localparam int WATCHDOG_LIMIT = 1000;
  // The block answers in the cycle after it accepts an item. A few spare cycles
  // cover that before a register write and at the end of the run.
  localparam int SETTLE_CYCLES = 4;

  // Phases of the sequencer as the predictor tracks them. The block reports
  // all three error phases as one box state.
  typedef enum logic [2:0] {
    FEEDER_IDLE,
    FEEDER_FEED,
    FEEDER_OUTPUT,
    FEEDER_IDLE_FAULT,
    FEEDER_FEED_FAULT,
    FEEDER_OUTPUT_FAULT
  } feeder_phase_t;

  // One result item, as the results channel carries it.
  typedef struct packed {
    logic [BOX_W-1:0] box_state;
    logic             keep_printing;
    logic             job_retired;
    logic             queue_full;
  } box_report_t;

  logic clk;
  logic rst;

  sfs_item_if   item_bus();
  sfs_result_if result_bus();
  sfs_cfg_if    cfg_bus();

  sheet_feeder_sequencer #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .items   (item_bus),
    .results (result_bus),
    .cfg     (cfg_bus)
  );

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predicted box reports, oldest first, waiting for the block to deliver them.
  box_report_t box_reports[$];
  box_report_t oldest_report;

  // Our own copy of the sequencer state and its two timeouts.
  feeder_phase_t      feeder_phase;
  logic [TIMER_W-1:0] phase_ticks;
  logic               job_in_progress;
  logic [SHEET_W-1:0] sheets_to_go;
  logic [SHEET_W-1:0] job_fifo [QUEUE_DEPTH];
  int                 fifo_head;
  int                 fifo_tail;
  int                 fifo_count;
  logic [TIMEOUT_W-1:0] feed_limit;
  logic [TIMEOUT_W-1:0] output_limit;

  int fault_count;
  int items_sent;
  int idle_cycles;

  // idling_on enables random gaps on both sides. hold_request asks the receiver
  // process for one long hold-off, its length set by hold_length.
  bit idling_on;
  bit hold_request;
  int hold_length;

  // Applies one accepted item to the predicted state and returns the report
  // the block must produce for it.
  function automatic box_report_t advance_feeder(input logic [OPCODE_W-1:0] op,
                                                 input logic upper, input logic lower,
                                                 input logic [SHEET_W-1:0] sheets);
    box_report_t report;
    logic        retired;
    logic        dropped;
    logic        settled;
    retired = 1'b0;
    dropped = 1'b0;
    if (op == OP_JOB) begin
      // A job only touches the queue; the sensor levels are ignored.
      if (fifo_count >= QUEUE_DEPTH) begin
        dropped = 1'b1;
      end else begin
        job_fifo[fifo_tail] = sheets;
        fifo_tail = (fifo_tail + 1) % QUEUE_DEPTH;
        fifo_count++;
      end
    end else begin
      // A tick runs the transition chain until some phase has to wait for the
      // next tick. The chain is bounded at eight steps.
      settled = 1'b0;
      for (int pass_no = 0; pass_no < 8 && !settled; pass_no++) begin
        case (feeder_phase)
          FEEDER_FEED: begin
            if (upper) begin
              feeder_phase = FEEDER_OUTPUT;
              phase_ticks = '0;
              settled = 1'b1;
            end else if (phase_ticks >= feed_limit) begin
              feeder_phase = FEEDER_FEED_FAULT;
            end else begin
              if (phase_ticks != '1) phase_ticks++;
              settled = 1'b1;
            end
          end
          FEEDER_OUTPUT: begin
            if (!upper) begin
              // The sheet has left: count it off. A job that had zero or one
              // sheet left retires here.
              if (sheets_to_go <= 1) begin
                sheets_to_go = '0;
                job_in_progress = 1'b0;
                retired = 1'b1;
              end else begin
                sheets_to_go--;
              end
              feeder_phase = FEEDER_IDLE;
            end else if (phase_ticks >= output_limit) begin
              feeder_phase = FEEDER_OUTPUT_FAULT;
            end else begin
              if (phase_ticks != '1) phase_ticks++;
              settled = 1'b1;
            end
          end
          FEEDER_IDLE_FAULT, FEEDER_FEED_FAULT, FEEDER_OUTPUT_FAULT: begin
            if (lower && !upper) feeder_phase = FEEDER_IDLE;
            else settled = 1'b1;
          end
          default: begin
            feeder_phase = FEEDER_IDLE;
            if (!lower) begin
              // Nothing to feed: that is a feed error right away.
              feeder_phase = FEEDER_FEED_FAULT;
            end else begin
              if (!job_in_progress && fifo_count != 0) begin
                sheets_to_go = job_fifo[fifo_head];
                fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
                fifo_count--;
                job_in_progress = 1'b1;
              end
              if (job_in_progress) begin
                feeder_phase = FEEDER_FEED;
                phase_ticks = '0;
              end
            end
            settled = 1'b1;
          end
        endcase
      end
    end
    case (feeder_phase)
      FEEDER_FEED:   report.box_state = BOX_FEED;
      FEEDER_OUTPUT: report.box_state = BOX_OUTPUT;
      FEEDER_IDLE_FAULT, FEEDER_FEED_FAULT, FEEDER_OUTPUT_FAULT: report.box_state = BOX_ERROR;
      default:       report.box_state = BOX_IDLE;
    endcase
    report.keep_printing = (report.box_state == BOX_FEED) || (report.box_state == BOX_OUTPUT);
    report.job_retired = retired;
    report.queue_full = dropped;
    return report;
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fault_count++;
    end
  endfunction

  // Every result taken from the block is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (box_reports.size() == 0) begin
        $error("result with nothing expected: box_state %0d", result_bus.box_state);
        fault_count++;
      end else begin
        oldest_report = box_reports.pop_front();
        check_field("box_state", oldest_report.box_state, result_bus.box_state);
        check_field("keep_printing", oldest_report.keep_printing, result_bus.keep_printing);
        check_field("job_retired", oldest_report.job_retired, result_bus.job_retired);
        check_field("queue_full", oldest_report.queue_full, result_bus.queue_full);
      end
    end
  end

  // The receiver. Normally it takes results at once, with random short stalls
  // while idling is on. On request it holds off for one long stretch so that
  // the result register stays full and the block has to refuse new items.
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_bus.ready <= 1'b0;
        repeat (hold_length) @(posedge clk);
        result_bus.ready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        result_bus.ready <= 1'b1;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // The run counts as hung when no channel accepts anything for too long.
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one item and waits until the block takes it. Valid stays high on
  // return, so a following call can present its item in the very next cycle;
  // anything that waits must first call settle, which drops valid.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic upper,
                           input logic lower, input logic [SHEET_W-1:0] sheets);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    item_bus.valid        <= 1'b1;
    item_bus.opcode       <= op;
    item_bus.upper_sensor <= upper;
    item_bus.lower_sensor <= lower;
    item_bus.sheet_count  <= sheets;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    box_reports.push_back(advance_feeder(op, upper, lower, sheets));
    items_sent++;
  endtask

  // A tick carries a random sheet count, which the block must ignore.
  task automatic send_tick(input logic upper, input logic lower);
    send_item(OP_TICK, upper, lower, SHEET_W'($urandom_range(0, 16'hFFFF)));
  endtask

  // Stops offering items and waits until every predicted result has come,
  // plus a spare wait of SETTLE_CYCLES for anything still in flight inside the block.
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (box_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one timeout register; only called with the block settled.
  task automatic write_timeout(input logic [CFG_INDEX_W-1:0] which,
                               input logic [TIMEOUT_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= which;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (which == CFG_FEED_TIMEOUT) feed_limit = value;
    else output_limit = value;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // One well-formed sheet pass: pull a sheet in with the lower sensor on,
  // wait in feed, see it at the upper sensor, wait in output, then let it go.
  // The lower sensor is random while waiting, so it may drop out under way.
  task automatic run_sheet(input int feed_wait, input int output_wait);
    send_tick(1'b0, 1'b1);
    repeat (feed_wait) send_tick(1'b0, 1'($urandom_range(0, 1)));
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (output_wait) send_tick(1'b1, 1'($urandom_range(0, 1)));
    send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  // Queues a job. Small sheet counts keep jobs retiring so the queue keeps
  // moving; when the queue is known to be full a random 16-bit count is sent
  // instead, which the block must drop.
  task automatic enqueue_job();
    logic [SHEET_W-1:0] sheets;
    if (fifo_count >= QUEUE_DEPTH) sheets = SHEET_W'($urandom_range(0, 16'hFFFF));
    else if ($urandom_range(0, 9) == 0) sheets = SHEET_W'($urandom_range(6, 20));
    else sheets = SHEET_W'($urandom_range(0, 5));
    send_item(OP_JOB, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sheets);
  endtask

  // Mostly sheet passes with random waits, mixed with jobs and stray ticks
  // carrying random sensor levels.
  task automatic run_mixed_traffic(input int count, input int feed_max, input int output_max);
    int stop_at;
    int pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) enqueue_job();
      else if (pick < 9) run_sheet($urandom_range(0, feed_max), $urandom_range(0, output_max));
      else send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Hand-picked items at the default timeouts: the feed error on a missing
  // sheet, the ways out of an error, idling without a job, a queue filled to
  // the brim with one job dropped, a zero-sheet job and a one-sheet job
  // retiring back to back.
  task automatic test_directed_sequence();
    send_tick(1'b0, 1'b0);   // no sheet below: feed error
    send_tick(1'b1, 1'b1);   // upper still on: stays in error
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);   // clears to idle, no job so it waits there
    send_tick(1'b0, 1'b1);
    send_item(OP_JOB, 1'b1, 1'b1, SHEET_W'(0));
    send_item(OP_JOB, 1'b0, 1'b0, SHEET_W'(1));
    send_item(OP_JOB, 1'b1, 1'b0, SHEET_W'(2));
    send_item(OP_JOB, 1'b0, 1'b1, SHEET_W'(3));
    send_item(OP_JOB, 1'b0, 1'b1, SHEET_W'(1));
    send_item(OP_JOB, 1'b0, 1'b1, SHEET_W'(2));
    send_item(OP_JOB, 1'b0, 1'b1, SHEET_W'(1));
    send_item(OP_JOB, 1'b0, 1'b1, SHEET_W'(4));
    send_item(OP_JOB, 1'b1, 1'b1, SHEET_W'(16'hFFFF));   // ninth job: dropped
    send_tick(1'b0, 1'b1);   // pops the zero-sheet job and starts feeding
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);   // sheet reaches the upper sensor
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);   // retires, then goes straight on with the next job
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);   // retires, and with no sheet below ends in error
    settle();
  endtask

  // Random traffic under a sweep of timeout settings: zero, one, the largest
  // value, fixed mixed pairs and random ones. For settings up to 8, waits reach
  // two past the timeout so that both sides of the limit are hit.
  task automatic test_timeout_settings();
    logic [TIMEOUT_W-1:0] feed_setting;
    logic [TIMEOUT_W-1:0] output_setting;
    for (int setting = 0; setting < 7; setting++) begin
      case (setting)
        0: begin feed_setting = '0; output_setting = '0; end
        1: begin feed_setting = 16'd1; output_setting = 16'd1; end
        2: begin feed_setting = 16'd2; output_setting = 16'd5; end
        3: begin feed_setting = '1; output_setting = '1; end
        4: begin feed_setting = 16'd6; output_setting = 16'd0; end
        5: begin
          feed_setting = TIMEOUT_W'($urandom_range(1, 8));
          output_setting = TIMEOUT_W'($urandom_range(1, 8));
        end
        default: begin
          feed_setting = TIMEOUT_W'($urandom_range(1, 16'hFFFF));
          output_setting = TIMEOUT_W'($urandom_range(1, 16'hFFFF));
        end
      endcase
      settle();
      write_timeout(CFG_FEED_TIMEOUT, feed_setting);
      write_timeout(CFG_OUTPUT_TIMEOUT, output_setting);
      run_mixed_traffic(180, (feed_setting > 8) ? 10 : feed_setting + 2,
                        (output_setting > 8) ? 10 : output_setting + 2);
    end
    settle();
  endtask

  // The receiver holds off for a long stretch while items keep coming with no
  // gaps, so the block has to back up its input. Afterwards the sender waits
  // for every outstanding result before moving on.
  task automatic test_output_stall();
    idling_on = 1'b0;
    hold_length = 48;
    hold_request = 1'b1;
    repeat (3) enqueue_job();
    repeat (6) run_sheet(1, 1);
    settle();
    idling_on = 1'b1;
  endtask

  // The closing stretch runs back to back with no idling on either side.
  task automatic test_quiet_stream();
    idling_on = 1'b0;
    write_timeout(CFG_FEED_TIMEOUT, TIMEOUT_W'(3));
    write_timeout(CFG_OUTPUT_TIMEOUT, TIMEOUT_W'(4));
    run_mixed_traffic(300, 5, 6);
    settle();
  endtask

  initial begin
    rst <= 1'b1;
    item_bus.valid        <= 1'b0;
    item_bus.opcode       <= OP_TICK;
    item_bus.upper_sensor <= 1'b0;
    item_bus.lower_sensor <= 1'b0;
    item_bus.sheet_count  <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_FEED_TIMEOUT;
    cfg_bus.data  <= '0;

    // Predicted state after reset.
    feeder_phase    = FEEDER_IDLE;
    phase_ticks     = '0;
    job_in_progress = 1'b0;
    sheets_to_go    = '0;
    fifo_head       = 0;
    fifo_tail       = 0;
    fifo_count      = 0;
    feed_limit      = FEED_TIMEOUT_RESET;
    output_limit    = OUTPUT_TIMEOUT_RESET;
    fault_count     = 0;
    items_sent      = 0;
    idle_cycles     = 0;
    idling_on       = 1'b1;
    hold_request    = 1'b0;
    hold_length     = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_sequence();
    test_timeout_settings();
    test_output_stall();
    test_quiet_stream();

    if (fault_count == 0 && box_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/sfs_pkg.sv
hdl/sfs_item_if.sv
hdl/sfs_result_if.sv
hdl/sfs_cfg_if.sv
hdl/sfs_job_queue.sv
hdl/sfs_phase_ctrl.sv
hdl/sheet_feeder_sequencer.sv
tb/sheet_feeder_sequencer_test.sv
